// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the triangle circumcircle block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCC_ASSERT_IMPL(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCC_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, constants and pipeline types of the triangle circumcircle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = 17;
  localparam int SUM_W      = 18;
  localparam int PROD_W     = 33;
  localparam int SQS_W      = 32;
  localparam int DETS_W     = 35;
  localparam int DET_W      = 36;
  localparam int DMAG_W     = 35;
  localparam int TERM_W     = 50;
  localparam int NUM_W      = 51;
  localparam int NMAG_W     = 50;
  localparam int DXY_W      = 52;
  localparam int OUT_W      = 32;
  localparam int LIMIT_W    = 16;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int SREM_W     = 34;
  localparam int CMAG_W     = 17;
  localparam int DIV3_W     = 18;
  localparam int DIV3_SHIFT = 19;
  localparam int DIV_CELLS  = NMAG_W;
  localparam int SQRT_CELLS = ROOT_W;

  // ceil(2^19 / 3): exact divide by three for magnitudes below 2^19
  localparam logic [DIV3_W-1:0]  DIV3_MUL    = 18'd174763;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

  typedef struct packed {
    logic                      valid;
    logic [DMAG_W-1:0]         dv;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] cent_x;
    logic signed [COORD_W-1:0] cent_y;
    logic                      degen;
  } div_side_t;

  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [NMAG_W-1:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] ctr_x;
    logic signed [OUT_W-1:0] ctr_y;
    logic                    degen;
    logic                    ovf;
    logic                    rad_sat;
  } sqrt_side_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] ctr_x;
    logic signed [OUT_W-1:0] ctr_y;
    logic [OUT_W-1:0]        radius;
    logic                    degen;
    logic                    ovf;
  } res_t;

endpackage

// ----- sv/tcc_if.sv -----
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channels for corner items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tcc_pkg::COORD_W-1:0] first_x;
  logic signed [tcc_pkg::COORD_W-1:0] first_y;
  logic signed [tcc_pkg::COORD_W-1:0] second_x;
  logic signed [tcc_pkg::COORD_W-1:0] second_y;
  logic signed [tcc_pkg::COORD_W-1:0] third_x;
  logic signed [tcc_pkg::COORD_W-1:0] third_y;

  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface tcc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tcc_pkg::OUT_W-1:0] center_x;
  logic signed [tcc_pkg::OUT_W-1:0] center_y;
  logic [tcc_pkg::OUT_W-1:0]        radius;
  logic                             degenerate;
  logic                             overflow;

  modport source (output valid, center_x, center_y, radius, degenerate, overflow,
                  input ready);
  modport sink (input valid, center_x, center_y, radius, degenerate, overflow,
                output ready);
endinterface

// ----- sv/tcc_div_cell.sv -----
// ----------------------------------------------------------------------------
// tcc_div_cell
// One restoring-division cell: one quotient bit for the x and y lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcc_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tcc_pkg::div_side_t in_side,
  input  tcc_pkg::div_lane_t in_lx,
  input  tcc_pkg::div_lane_t in_ly,
  output tcc_pkg::div_side_t out_side,
  output tcc_pkg::div_lane_t out_lx,
  output tcc_pkg::div_lane_t out_ly
);

  function automatic tcc_pkg::div_lane_t div_step(input tcc_pkg::div_lane_t l,
                                                  input logic [tcc_pkg::DMAG_W-1:0] dv);
    logic [tcc_pkg::DMAG_W:0] r2;
    logic [tcc_pkg::DMAG_W:0] dv_x;
    logic [tcc_pkg::DMAG_W:0] diff;
    logic                     ge;
    tcc_pkg::div_lane_t       o;
    r2    = {l.rem, l.nq[tcc_pkg::NMAG_W-1]};
    dv_x  = {1'b0, dv};
    diff  = r2 - dv_x;
    ge    = (r2 >= dv_x);
    o.rem = ge ? diff[tcc_pkg::DMAG_W-1:0] : r2[tcc_pkg::DMAG_W-1:0];
    o.nq  = {l.nq[tcc_pkg::NMAG_W-2:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_side.valid <= 1'b0;
    end else if (en) begin
      out_side <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lx <= div_step(in_lx, in_side.dv);
      out_ly <= div_step(in_ly, in_side.dv);
    end
  end

  `TCC_ASSERT_IMPL(a_rem_below_divisor, clk, rst, out_side.valid && (out_side.dv != '0), (out_lx.rem < out_side.dv) && (out_ly.rem < out_side.dv), "partial remainder reached the divisor")

endmodule

// ----- sv/tcc_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tcc_sqrt_cell
// One digit-recurrence square-root cell: one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcc_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tcc_pkg::sqrt_side_t in_side,
  input  tcc_pkg::sqrt_lane_t in_lane,
  output tcc_pkg::sqrt_side_t out_side,
  output tcc_pkg::sqrt_lane_t out_lane
);

  function automatic tcc_pkg::sqrt_lane_t sqrt_step(input tcc_pkg::sqrt_lane_t l);
    logic [tcc_pkg::SREM_W+1:0] t;
    logic [tcc_pkg::SREM_W+1:0] trial;
    logic [tcc_pkg::SREM_W+1:0] diff;
    logic                       ge;
    tcc_pkg::sqrt_lane_t        o;
    t      = {l.rem, l.rad[tcc_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, l.root, 2'b01};
    diff   = t - trial;
    ge     = (t >= trial);
    o.rem  = ge ? diff[tcc_pkg::SREM_W-1:0] : t[tcc_pkg::SREM_W-1:0];
    o.root = {l.root[tcc_pkg::ROOT_W-2:0], ge};
    o.rad  = {l.rad[tcc_pkg::SQ_W-3:0], 2'b00};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_side.valid <= 1'b0;
    end else if (en) begin
      out_side <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= sqrt_step(in_lane);
    end
  end

  `TCC_ASSERT_IMPL(a_rem_bounded, clk, rst, out_side.valid, out_lane.rem <= {out_lane.root, 1'b0}, "root remainder exceeds twice the root")

endmodule

// ----- sv/triangle_circumcircle_top.sv -----
// Triangle circumcircle unit. Takes one triangle item per clock cycle while
// input ready is high and returns one result item per triangle, in order.
// Items pass through the front-end stages, a chain of 50 division cells
// (one quotient bit each, x and y in parallel), the post stages, a chain of
// 32 square-root cells (one root bit each) and the output register.
// Results sit in an output register with a one-item skid stage, so input ready
// depends only on whether the skid stage is occupied. The degenerate limit is
// written through limit_we/limit_wdata; the user must write it while the unit
// is idle, the block itself does not enforce this. It resets to 1.
// ----------------------------------------------------------------------------
// triangle_circumcircle_top
// Circumcenter and radius of a triangle, or centroid when degenerate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_circumcircle_top (
  input  logic                         clk,
  input  logic                         rst,
  tcc_in_if.sink                       corners,
  tcc_out_if.source                    result,
  input  logic                         limit_we,
  input  logic [tcc_pkg::LIMIT_W-1:0]  limit_wdata
);

  localparam int CW = tcc_pkg::COORD_W;

  logic                        en;
  logic                        push;
  logic                        main_v;
  logic                        skid_v;
  tcc_pkg::res_t               main_res;
  tcc_pkg::res_t               skid_res;
  tcc_pkg::res_t               push_res;
  logic [tcc_pkg::LIMIT_W-1:0] limit;

  assign en            = !skid_v;
  assign corners.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= tcc_pkg::LIMIT_RESET;
    end else if (limit_we) begin
      limit <= limit_wdata;
    end
  end

  // stage 0: input capture
  logic                 v0;
  logic signed [CW-1:0] s0_ax, s0_ay, s0_bx, s0_by, s0_cx, s0_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= corners.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax <= corners.first_x;
      s0_ay <= corners.first_y;
      s0_bx <= corners.second_x;
      s0_by <= corners.second_y;
      s0_cx <= corners.third_x;
      s0_cy <= corners.third_y;
    end
  end

  // stage 1: differences, cross products, squared norms, coordinate sums
  logic signed [tcc_pkg::DIFF_W-1:0] c1_dbcy, c1_dcay, c1_daby, c1_dcbx, c1_dacx, c1_dbax;
  logic signed [tcc_pkg::PROD_W-1:0] c1_pa, c1_pb, c1_pc;
  logic signed [tcc_pkg::SQS_W-1:0]  c1_qax, c1_qay, c1_qbx, c1_qby, c1_qcx, c1_qcy;
  logic signed [tcc_pkg::SUM_W-1:0]  c1_sumx, c1_sumy;

  assign c1_dbcy = {s0_by[CW-1], s0_by} - {s0_cy[CW-1], s0_cy};
  assign c1_dcay = {s0_cy[CW-1], s0_cy} - {s0_ay[CW-1], s0_ay};
  assign c1_daby = {s0_ay[CW-1], s0_ay} - {s0_by[CW-1], s0_by};
  assign c1_dcbx = {s0_cx[CW-1], s0_cx} - {s0_bx[CW-1], s0_bx};
  assign c1_dacx = {s0_ax[CW-1], s0_ax} - {s0_cx[CW-1], s0_cx};
  assign c1_dbax = {s0_bx[CW-1], s0_bx} - {s0_ax[CW-1], s0_ax};
  assign c1_pa   = s0_ax * c1_dbcy;
  assign c1_pb   = s0_bx * c1_dcay;
  assign c1_pc   = s0_cx * c1_daby;
  assign c1_qax  = s0_ax * s0_ax;
  assign c1_qay  = s0_ay * s0_ay;
  assign c1_qbx  = s0_bx * s0_bx;
  assign c1_qby  = s0_by * s0_by;
  assign c1_qcx  = s0_cx * s0_cx;
  assign c1_qcy  = s0_cy * s0_cy;
  assign c1_sumx = {{2{s0_ax[CW-1]}}, s0_ax} + {{2{s0_bx[CW-1]}}, s0_bx}
                 + {{2{s0_cx[CW-1]}}, s0_cx};
  assign c1_sumy = {{2{s0_ay[CW-1]}}, s0_ay} + {{2{s0_by[CW-1]}}, s0_by}
                 + {{2{s0_cy[CW-1]}}, s0_cy};

  logic                              v1;
  logic signed [tcc_pkg::PROD_W-1:0] s1_pa, s1_pb, s1_pc;
  logic [tcc_pkg::SQS_W-1:0]         s1_sa, s1_sb, s1_sc;
  logic signed [tcc_pkg::DIFF_W-1:0] s1_dbcy, s1_dcay, s1_daby, s1_dcbx, s1_dacx, s1_dbax;
  logic signed [CW-1:0]              s1_ax, s1_ay;
  logic signed [tcc_pkg::SUM_W-1:0]  s1_sumx, s1_sumy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa   <= c1_pa;
      s1_pb   <= c1_pb;
      s1_pc   <= c1_pc;
      s1_sa   <= c1_qax + c1_qay;
      s1_sb   <= c1_qbx + c1_qby;
      s1_sc   <= c1_qcx + c1_qcy;
      s1_dbcy <= c1_dbcy;
      s1_dcay <= c1_dcay;
      s1_daby <= c1_daby;
      s1_dcbx <= c1_dcbx;
      s1_dacx <= c1_dacx;
      s1_dbax <= c1_dbax;
      s1_ax   <= s0_ax;
      s1_ay   <= s0_ay;
      s1_sumx <= c1_sumx;
      s1_sumy <= c1_sumy;
    end
  end

  // stage 2: determinant, numerator terms, centroid divide by three
  localparam int PW = tcc_pkg::PROD_W;
  localparam int SW = tcc_pkg::SUM_W;

  logic signed [tcc_pkg::DETS_W-1:0] c2_dsum;
  logic signed [tcc_pkg::TERM_W-1:0] c2_txa, c2_txb, c2_txc, c2_tya, c2_tyb, c2_tyc;
  logic signed [tcc_pkg::SQS_W:0]    c2_sa, c2_sb, c2_sc;
  logic [SW-1:0]                     c2_absx, c2_absy;
  logic [tcc_pkg::CMAG_W+tcc_pkg::DIV3_W-1:0] c2_px, c2_py;

  assign c2_dsum = {{2{s1_pa[PW-1]}}, s1_pa} + {{2{s1_pb[PW-1]}}, s1_pb}
                 + {{2{s1_pc[PW-1]}}, s1_pc};
  assign c2_sa   = {1'b0, s1_sa};
  assign c2_sb   = {1'b0, s1_sb};
  assign c2_sc   = {1'b0, s1_sc};
  assign c2_txa  = c2_sa * s1_dbcy;
  assign c2_txb  = c2_sb * s1_dcay;
  assign c2_txc  = c2_sc * s1_daby;
  assign c2_tya  = c2_sa * s1_dcbx;
  assign c2_tyb  = c2_sb * s1_dacx;
  assign c2_tyc  = c2_sc * s1_dbax;
  assign c2_absx = s1_sumx[SW-1] ? -s1_sumx : s1_sumx;
  assign c2_absy = s1_sumy[SW-1] ? -s1_sumy : s1_sumy;
  assign c2_px   = c2_absx[tcc_pkg::CMAG_W-1:0] * tcc_pkg::DIV3_MUL;
  assign c2_py   = c2_absy[tcc_pkg::CMAG_W-1:0] * tcc_pkg::DIV3_MUL;

  logic                              v2;
  logic signed [tcc_pkg::DET_W-1:0]  s2_d;
  logic signed [tcc_pkg::TERM_W-1:0] s2_txa, s2_txb, s2_txc, s2_tya, s2_tyb, s2_tyc;
  logic [CW-1:0]                     s2_qx, s2_qy;
  logic                              s2_negx, s2_negy;
  logic signed [CW-1:0]              s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d    <= {c2_dsum, 1'b0};
      s2_txa  <= c2_txa;
      s2_txb  <= c2_txb;
      s2_txc  <= c2_txc;
      s2_tya  <= c2_tya;
      s2_tyb  <= c2_tyb;
      s2_tyc  <= c2_tyc;
      s2_qx   <= c2_px[tcc_pkg::DIV3_SHIFT +: CW];
      s2_qy   <= c2_py[tcc_pkg::DIV3_SHIFT +: CW];
      s2_negx <= s1_sumx[SW-1];
      s2_negy <= s1_sumy[SW-1];
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
    end
  end

  // stage 3: numerators, |D|, degenerate test, signed centroid
  localparam int TW = tcc_pkg::TERM_W;

  logic [tcc_pkg::DET_W-1:0] c3_dabs;
  logic [tcc_pkg::DMAG_W-1:0] c3_dmag;
  logic [tcc_pkg::DMAG_W-1:0] c3_limit;

  assign c3_dabs  = s2_d[tcc_pkg::DET_W-1] ? -s2_d : s2_d;
  assign c3_dmag  = c3_dabs[tcc_pkg::DMAG_W-1:0];
  assign c3_limit = {{(tcc_pkg::DMAG_W-tcc_pkg::LIMIT_W){1'b0}}, limit};

  logic                              v3;
  logic signed [tcc_pkg::NUM_W-1:0]  s3_nx, s3_ny;
  logic [tcc_pkg::DMAG_W-1:0]        s3_dmag;
  logic                              s3_dneg;
  logic                              s3_degen;
  logic signed [CW-1:0]              s3_centx, s3_centy;
  logic signed [CW-1:0]              s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nx    <= {s2_txa[TW-1], s2_txa} + {s2_txb[TW-1], s2_txb} + {s2_txc[TW-1], s2_txc};
      s3_ny    <= {s2_tya[TW-1], s2_tya} + {s2_tyb[TW-1], s2_tyb} + {s2_tyc[TW-1], s2_tyc};
      s3_dmag  <= c3_dmag;
      s3_dneg  <= s2_d[tcc_pkg::DET_W-1];
      s3_degen <= (c3_dmag == '0) || (c3_dmag < c3_limit);
      s3_centx <= s2_negx ? -s2_qx : s2_qx;
      s3_centy <= s2_negy ? -s2_qy : s2_qy;
      s3_ax    <= s2_ax;
      s3_ay    <= s2_ay;
    end
  end

  // division chain: |N| / |D|, sign applied afterwards
  localparam int NW = tcc_pkg::NUM_W;

  logic [NW-1:0]      c4_nabsx, c4_nabsy;
  tcc_pkg::div_side_t dside [0:tcc_pkg::DIV_CELLS];
  tcc_pkg::div_lane_t dlx   [0:tcc_pkg::DIV_CELLS];
  tcc_pkg::div_lane_t dly   [0:tcc_pkg::DIV_CELLS];

  assign c4_nabsx = s3_nx[NW-1] ? -s3_nx : s3_nx;
  assign c4_nabsy = s3_ny[NW-1] ? -s3_ny : s3_ny;

  always_comb begin
    dside[0].valid  = v3;
    dside[0].dv     = s3_dmag;
    dside[0].neg_x  = s3_nx[NW-1] ^ s3_dneg;
    dside[0].neg_y  = s3_ny[NW-1] ^ s3_dneg;
    dside[0].ax     = s3_ax;
    dside[0].ay     = s3_ay;
    dside[0].cent_x = s3_centx;
    dside[0].cent_y = s3_centy;
    dside[0].degen  = s3_degen;
    dlx[0].rem      = '0;
    dlx[0].nq       = c4_nabsx[tcc_pkg::NMAG_W-1:0];
    dly[0].rem      = '0;
    dly[0].nq       = c4_nabsy[tcc_pkg::NMAG_W-1:0];
  end

  for (genvar i = 0; i < tcc_pkg::DIV_CELLS; i++) begin : g_div
    tcc_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_side  (dside[i]),
      .in_lx    (dlx[i]),
      .in_ly    (dly[i]),
      .out_side (dside[i+1]),
      .out_lx   (dlx[i+1]),
      .out_ly   (dly[i+1])
    );
  end

  // post 1: signed quotients
  tcc_pkg::div_side_t dlast;
  assign dlast = dside[tcc_pkg::DIV_CELLS];

  logic                 p1_v;
  logic signed [NW-1:0] p1_ux, p1_uy;
  logic signed [CW-1:0] p1_ax, p1_ay, p1_centx, p1_centy;
  logic                 p1_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= dlast.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ux    <= dlast.neg_x ? -{1'b0, dlx[tcc_pkg::DIV_CELLS].nq}
                              : {1'b0, dlx[tcc_pkg::DIV_CELLS].nq};
      p1_uy    <= dlast.neg_y ? -{1'b0, dly[tcc_pkg::DIV_CELLS].nq}
                              : {1'b0, dly[tcc_pkg::DIV_CELLS].nq};
      p1_ax    <= dlast.ax;
      p1_ay    <= dlast.ay;
      p1_centx <= dlast.cent_x;
      p1_centy <= dlast.cent_y;
      p1_degen <= dlast.degen;
    end
  end

  // post 2: offsets from first corner, center saturation
  localparam int OW = tcc_pkg::OUT_W;
  localparam int XW = tcc_pkg::DXY_W;

  logic                 c5_ovfx, c5_ovfy;
  logic signed [OW-1:0] c5_satx, c5_saty, c5_ctrx, c5_ctry;

  assign c5_ovfx = !((&p1_ux[NW-1:OW-1]) || !(|p1_ux[NW-1:OW-1]));
  assign c5_ovfy = !((&p1_uy[NW-1:OW-1]) || !(|p1_uy[NW-1:OW-1]));
  assign c5_satx = c5_ovfx ? {p1_ux[NW-1], {(OW-1){!p1_ux[NW-1]}}} : p1_ux[OW-1:0];
  assign c5_saty = c5_ovfy ? {p1_uy[NW-1], {(OW-1){!p1_uy[NW-1]}}} : p1_uy[OW-1:0];
  assign c5_ctrx = p1_degen ? {{(OW-CW){p1_centx[CW-1]}}, p1_centx} : c5_satx;
  assign c5_ctry = p1_degen ? {{(OW-CW){p1_centy[CW-1]}}, p1_centy} : c5_saty;

  logic                 p2_v;
  logic signed [XW-1:0] p2_dx, p2_dy;
  logic signed [OW-1:0] p2_ctrx, p2_ctry;
  logic                 p2_ovf, p2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dx    <= {p1_ux[NW-1], p1_ux} - {{(XW-CW){p1_ax[CW-1]}}, p1_ax};
      p2_dy    <= {p1_uy[NW-1], p1_uy} - {{(XW-CW){p1_ay[CW-1]}}, p1_ay};
      p2_ctrx  <= c5_ctrx;
      p2_ctry  <= c5_ctry;
      p2_ovf   <= c5_ovfx || c5_ovfy;
      p2_degen <= p1_degen;
    end
  end

  // post 3: magnitudes
  logic [XW-1:0] c6_mx, c6_my;
  assign c6_mx = p2_dx[XW-1] ? -p2_dx : p2_dx;
  assign c6_my = p2_dy[XW-1] ? -p2_dy : p2_dy;

  logic                 p3_v;
  logic [OW-1:0]        p3_mx, p3_my;
  logic                 p3_big;
  logic signed [OW-1:0] p3_ctrx, p3_ctry;
  logic                 p3_ovf, p3_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_mx    <= c6_mx[OW-1:0];
      p3_my    <= c6_my[OW-1:0];
      p3_big   <= (|c6_mx[XW-1:OW]) || (|c6_my[XW-1:OW]);
      p3_ctrx  <= p2_ctrx;
      p3_ctry  <= p2_ctry;
      p3_ovf   <= p2_ovf;
      p3_degen <= p2_degen;
    end
  end

  // post 4: squares
  logic                     p4_v;
  logic [tcc_pkg::SQ_W-1:0] p4_qx, p4_qy;
  logic                     p4_big;
  logic signed [OW-1:0]     p4_ctrx, p4_ctry;
  logic                     p4_ovf, p4_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_qx    <= p3_mx * p3_mx;
      p4_qy    <= p3_my * p3_my;
      p4_big   <= p3_big;
      p4_ctrx  <= p3_ctrx;
      p4_ctry  <= p3_ctry;
      p4_ovf   <= p3_ovf;
      p4_degen <= p3_degen;
    end
  end

  // post 5: squared distance
  logic [tcc_pkg::SQ_W:0]   c8_s;
  assign c8_s = {1'b0, p4_qx} + {1'b0, p4_qy};

  tcc_pkg::sqrt_side_t      p5_side;
  logic [tcc_pkg::SQ_W-1:0] p5_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_side.valid <= 1'b0;
    end else if (en) begin
      p5_side.valid   <= p4_v;
      p5_side.ctr_x   <= p4_ctrx;
      p5_side.ctr_y   <= p4_ctry;
      p5_side.degen   <= p4_degen;
      p5_side.ovf     <= p4_ovf;
      p5_side.rad_sat <= p4_big || c8_s[tcc_pkg::SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_s <= c8_s[tcc_pkg::SQ_W-1:0];
    end
  end

  // square-root chain
  tcc_pkg::sqrt_side_t sside [0:tcc_pkg::SQRT_CELLS];
  tcc_pkg::sqrt_lane_t slane [0:tcc_pkg::SQRT_CELLS];

  always_comb begin
    sside[0]      = p5_side;
    slane[0].rem  = '0;
    slane[0].root = '0;
    slane[0].rad  = p5_s;
  end

  for (genvar j = 0; j < tcc_pkg::SQRT_CELLS; j++) begin : g_sqrt
    tcc_sqrt_cell u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_side  (sside[j]),
      .in_lane  (slane[j]),
      .out_side (sside[j+1]),
      .out_lane (slane[j+1])
    );
  end

  // result assembly
  tcc_pkg::sqrt_side_t slast;
  logic [OW-1:0]       slast_root;
  assign slast      = sside[tcc_pkg::SQRT_CELLS];
  assign slast_root = slane[tcc_pkg::SQRT_CELLS].root;
  assign push       = en && slast.valid;

  always_comb begin
    push_res.ctr_x = slast.ctr_x;
    push_res.ctr_y = slast.ctr_y;
    push_res.degen = slast.degen;
    push_res.ovf   = !slast.degen && (slast.ovf || slast.rad_sat);
    if (slast.degen) begin
      push_res.radius = '0;
    end else if (slast.rad_sat) begin
      push_res.radius = '1;
    end else begin
      push_res.radius = slast_root;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!main_v || result.ready) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || result.ready) begin
      main_res <= skid_v ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  assign result.valid      = main_v;
  assign result.center_x   = main_res.ctr_x;
  assign result.center_y   = main_res.ctr_y;
  assign result.radius     = main_res.radius;
  assign result.degenerate = main_res.degen;
  assign result.overflow   = main_res.ovf;

  `TCC_ASSERT_IMPL(a_skid_needs_main, clk, rst, skid_v, main_v, "skid stage full while output register empty")
  `TCC_ASSERT_NEXT(a_stall_fills_skid, clk, rst, main_v && !result.ready && push, skid_v, "stalled item not caught by skid stage")
  `TCC_ASSERT_IMPL(a_degen_result, clk, rst, main_v && main_res.degen, (main_res.radius == '0) && !main_res.ovf, "degenerate item with radius or overflow")

endmodule

// ----- dv/tcc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_tb_pkg
// Triangle item type shared by the circumcircle testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_tb_pkg;

  import tcc_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tri_item_t;

endpackage

// ----- dv/triangle_circumcircle_top_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_circumcircle_top_tb
// Self-checking bench for the circumcircle unit. Triangle items are driven
// through a valid/ready channel under several idle and stall patterns; each
// result item is compared with a built-in integer model of the circumcenter,
// radius, centroid fallback and saturation, across several limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_circumcircle_top_tb;

  import tcc_pkg::*;
  import tcc_tb_pkg::*;

  localparam int LATENCY = 92;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic limit_we = 1'b0;
  logic [LIMIT_W-1:0] limit_wdata = '0;

  tcc_in_if  corners ();
  tcc_out_if result ();

  triangle_circumcircle_top uut (
    .clk         (clk),
    .rst         (rst),
    .corners     (corners),
    .result      (result),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata)
  );

  always #10 clk = ~clk;

  tri_item_t tri_q[$];
  res_t      circle_q[$];
  logic [LIMIT_W-1:0] limit_shadow;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  function automatic void add_tri(tri_item_t t);
    tri_q.insert(tri_q.size(), t);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp32(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic res_t circle_of(tri_item_t t, logic [LIMIT_W-1:0] lim);
    longint ax, ay, bx, by, cx, cy, d, sa, sb, sc, nx, ny, ux, uy, dmag;
    logic [63:0] mx, my, qx, qy, s, rad;
    logic ovf, degen;
    res_t r;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
    d = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
    dmag = d < 0 ? -d : d;
    degen = (d == 0) || (dmag < longint'(lim));
    ovf = 1'b0;
    rad = 0;
    if (degen) begin
      ux = (ax + bx + cx) / 3;
      uy = (ay + by + cy) / 3;
    end else begin
      sa = ax * ax + ay * ay;
      sb = bx * bx + by * by;
      sc = cx * cx + cy * cy;
      nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
      ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
      ux = nx / d;
      uy = ny / d;
      mx = (ux - ax) < 0 ? -(ux - ax) : (ux - ax);
      my = (uy - ay) < 0 ? -(uy - ay) : (uy - ay);
      if (mx > 64'hFFFF_FFFF || my > 64'hFFFF_FFFF) begin
        rad = 64'hFFFF_FFFF;
        ovf = 1'b1;
      end else begin
        qx = mx * mx;
        qy = my * my;
        s = qx + qy;
        if (s < qx) begin
          rad = 64'hFFFF_FFFF;
          ovf = 1'b1;
        end else begin
          rad = root_floor(s);
          if (rad > 64'hFFFF_FFFF) begin
            rad = 64'hFFFF_FFFF;
            ovf = 1'b1;
          end
        end
      end
      ux = clamp32(ux, ovf);
      uy = clamp32(uy, ovf);
    end
    r.ctr_x = ux[31:0];
    r.ctr_y = uy[31:0];
    r.radius = rad[31:0];
    r.degen = degen;
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // driver
  always @(posedge clk) begin
    tri_item_t t;
    if (rst) begin
      corners.valid <= 1'b0;
    end else if (!corners.valid || corners.ready) begin
      if (tri_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        t = tri_q.pop_front();
        circle_q.insert(circle_q.size(), circle_of(t, limit_shadow));
        corners.valid <= 1'b1;
        corners.first_x <= t.ax;
        corners.first_y <= t.ay;
        corners.second_x <= t.bx;
        corners.second_y <= t.by;
        corners.third_x <= t.cx;
        corners.third_y <= t.cy;
      end else begin
        corners.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (circle_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          w = circle_q.pop_front();
          if (result.center_x !== w.ctr_x)
            report_mismatch("center_x", result.center_x, w.ctr_x);
          if (result.center_y !== w.ctr_y)
            report_mismatch("center_y", result.center_y, w.ctr_y);
          if (result.radius !== w.radius)
            report_mismatch("radius", result.radius, w.radius);
          if (result.degenerate !== w.degen)
            report_mismatch("degenerate", result.degenerate, w.degen);
          if (result.overflow !== w.ovf)
            report_mismatch("overflow", result.overflow, w.ovf);
        end
      end
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    corners.valid = 1'b0;
    corners.first_x = '0;
    corners.first_y = '0;
    corners.second_x = '0;
    corners.second_y = '0;
    corners.third_x = '0;
    corners.third_y = '0;
    result.ready = 1'b0;
  end

  // the driver predicts at hand-off, so the item is tagged with the live limit
  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return $signed(16'($urandom));
      1: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      default: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                        : 16'sh8000 + 16'($urandom_range(3));
    endcase
  endfunction

  function automatic tri_item_t rand_tri();
    tri_item_t t;
    int m;
    int k;
    m = $urandom_range(2);
    t.ax = rand_coord(m); t.ay = rand_coord(m);
    t.bx = rand_coord(m); t.by = rand_coord(m);
    t.cx = rand_coord(m); t.cy = rand_coord(m);
    k = $urandom_range(9);
    if (k == 0) begin
      // collinear: c on line through a and b
      t.cx = t.ax + (t.bx - t.ax) * 2;
      t.cy = t.ay + (t.by - t.ay) * 2;
    end else if (k == 1) begin
      t.bx = t.ax; t.by = t.ay;
    end else if (k == 2) begin
      t.bx = t.ax + 16'($urandom_range(3));
      t.by = t.ay + 16'($urandom_range(3));
      t.cx = t.ax + 16'($urandom_range(3));
      t.cy = t.ay - 16'($urandom_range(3));
    end
    return t;
  endfunction

  task automatic drain();
    while (tri_q.size() > 0 || circle_q.size() > 0 || corners.valid) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    limit_we <= 1'b1;
    limit_wdata <= v;
    @(posedge clk);
    limit_we <= 1'b0;
    limit_shadow = v;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) add_tri(rand_tri());
    while (tri_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    tri_item_t t;
    limit_shadow = LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    add_tri('{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16});
    add_tri('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    add_tri('{16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd3, 16'sd3});
    add_tri('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
    add_tri('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    add_tri('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    add_tri('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8001, 16'sh8001});
    add_tri('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7ffe, 16'sh8001});
    add_tri('{16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd1});
    add_tri('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    add_tri('{16'sd0, 16'sd0, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd0});
    add_tri('{-16'sd5, -16'sd7, -16'sd1, -16'sd1, -16'sd2, -16'sd3});
    add_tri('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh1234, 16'shedcb});
    drain();
    // limit 0: only a zero determinant is degenerate
    set_limit(16'd0);
    add_tri('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    add_tri('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd2});
    random_phase(200, 0, 0);
    drain();
    set_limit(16'hffff);
    t = '{16'sd0, 16'sd0, 16'sd255, 16'sd0, 16'sd0, 16'sd128};
    add_tri(t);
    random_phase(300, 72, 0);
    drain();
    set_limit(16'd1);
    random_phase(300, 0, 72);
    // hold off the sender until the pipe empties
    drain();
    set_limit(16'd3);
    random_phase(300, 9, 9);
    drain();
    set_limit(16'($urandom));
    random_phase(300, $urandom_range(30), $urandom_range(30));
    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
